// File: src/uavr_pkg.sv
`default_nettype none
package uavr_pkg;

  localparam int WINDOW_DEPTH_DEF    = 7;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int MIN_SAMPLES         = 3;
  localparam int US_BITS             = 20;

  localparam longint unsigned PI_Q30   = 64'd3373259426;
  localparam logic [US_BITS-1:0] US_PER_S = 20'd1000000;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [15:0] angle_wrapped;
    logic [31:0]        time_us;
  } in_t;

  typedef struct packed {
    logic signed [31:0] velocity;
    logic [31:0]        period_us;
    logic signed [31:0] continuous_angle;
    logic               ready_res;
  } out_t;

  typedef struct packed {
    logic [31:0]        period_us;
    logic signed [31:0] continuous_angle;
    logic               ready_res;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PAIR,
    B_DRAIN,
    B_FIN,
    B_MUL,
    B_DIV,
    B_DONE
  } bst_e;

  function automatic int pi_fix(int f);
    longint unsigned v;
    v = (PI_Q30 + (64'd1 << (29 - f))) >> (30 - f);
    return int'(v);
  endfunction

  function automatic int wrap_steps(int m, int ymax);
    int k;
    k = 0;
    while ((longint'(m) << k) <= longint'(ymax)) begin
      k++;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// File: src/unwrapped_angle_velocity_regression_unit.sv
// Angle unwrap and least-squares velocity. The front stage takes one beat per
// cycle while its two-entry job queue has room, unwraps the angle, updates the
// period and the sample window, and hands the window to the back stage. The
// back stage walks the n(n-1)/2 sample pairs one per cycle through two 33x33
// multipliers, scales by 1e6 with a 20-step shift-add, then runs a 32-step
// restoring divider; it takes the next job only once the last has been loaded
// into the output register. Beats whose window holds under three samples,
// seeding beats among them, skip the regression. Results leave through an
// output register in input order.
`default_nettype none
module unwrapped_angle_velocity_regression_unit import uavr_pkg::*; #(
  parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int JW = WINDOW_DEPTH * 64 + CW + $bits(res_t);

  logic                          push, room, pop, avail;
  logic [WINDOW_DEPTH-1:0][31:0] f_angle, f_time, b_angle, b_time;
  logic [CW-1:0]                 f_n, b_n;
  res_t                          f_res, b_res;
  logic [JW-1:0]                 q_in, q_out;

  uavr_front #(
    .WINDOW_DEPTH   (WINDOW_DEPTH),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_ready_o (in_ready_o),
    .room_i     (room),
    .push_o     (push),
    .job_angle_o(f_angle),
    .job_time_o (f_time),
    .job_n_o    (f_n),
    .job_res_o  (f_res)
  );

  assign q_in = {f_n, f_res, f_angle, f_time};

  uavr_queue #(
    .WIDTH(JW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .room_o (room),
    .pop_i  (pop),
    .data_o (q_out),
    .avail_o(avail)
  );

  assign {b_n, b_res, b_angle, b_time} = q_out;

  uavr_back #(
    .WINDOW_DEPTH   (WINDOW_DEPTH),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (avail),
    .job_angle_i(b_angle),
    .job_time_i (b_time),
    .job_n_i    (b_n),
    .job_res_i  (b_res),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

// File: src/uavr_front.sv
`default_nettype none
module uavr_front import uavr_pkg::*; #(
  parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  localparam int CW = $clog2(WINDOW_DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire in_t                           in_i,
  output logic                               in_ready_o,
  input  wire logic                          room_i,
  output logic                               push_o,
  output logic [WINDOW_DEPTH-1:0][31:0]      job_angle_o,
  output logic [WINDOW_DEPTH-1:0][31:0]      job_time_o,
  output logic [CW-1:0]                      job_n_o,
  output res_t                               job_res_o
);

  localparam int IW     = $clog2(WINDOW_DEPTH);
  localparam int PI     = pi_fix(ANGLE_FRAC_BITS);
  localparam int TWO_PI = 2 * PI;
  localparam int OFF    = TWO_PI * ((65536 + TWO_PI - 1) / TWO_PI);
  localparam int YMAX   = 65535 + PI + OFF;
  localparam int KSTEPS = wrap_steps(TWO_PI, YMAX);
  localparam int YW     = 27;
  localparam logic [YW-1:0] MY   = YW'(TWO_PI);
  localparam logic [YW-1:0] BIAS = YW'(PI + OFF);

  logic                             started_q, started_d;
  logic [CW-1:0]                    fill_q, fill_d;
  logic signed [15:0]               last_q, last_d;
  logic signed [31:0]               unw_q, unw_d;
  logic [31:0]                      ltime_q, ltime_d;
  logic [31:0]                      held_q, held_d;
  logic [WINDOW_DEPTH-1:0][31:0]    aw_q, aw_d;
  logic [WINDOW_DEPTH-1:0][31:0]    tw_q, tw_d;

  logic              seed;
  logic [16:0]       d17;
  logic [YW-1:0]     y;
  logic signed [31:0] dwrap;
  logic [32:0]       sum;
  logic signed [31:0] unw_step;
  logic [31:0]       dt;

  always_comb begin
    seed = (in_i.op == OP_RESTART) || !started_q;
    d17  = {in_i.angle_wrapped[15], in_i.angle_wrapped} - {last_q[15], last_q};
    y    = {{(YW-17){d17[16]}}, d17} + BIAS;
    for (int k = KSTEPS - 1; k >= 0; k--) begin
      if (y >= (MY << k)) begin
        y = y - (MY << k);
      end
    end
    dwrap = 32'(y) - 32'(PI);
    sum   = {unw_q[31], unw_q} + {dwrap[31], dwrap};
    if (sum[32] != sum[31]) begin
      unw_step = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      unw_step = sum[31:0];
    end
    dt = in_i.time_us - ltime_q;
  end

  always_comb begin
    started_d = started_q;
    fill_d    = fill_q;
    last_d    = last_q;
    unw_d     = unw_q;
    ltime_d   = ltime_q;
    held_d    = held_q;
    aw_d      = aw_q;
    tw_d      = tw_q;
    if (seed) begin
      started_d = 1'b1;
      fill_d    = CW'(1);
      last_d    = in_i.angle_wrapped;
      unw_d     = {{16{in_i.angle_wrapped[15]}}, in_i.angle_wrapped};
      ltime_d   = in_i.time_us;
      held_d    = '0;
      aw_d[0]   = {{16{in_i.angle_wrapped[15]}}, in_i.angle_wrapped};
      tw_d[0]   = in_i.time_us;
    end else begin
      ltime_d = in_i.time_us;
      if (dt != '0) begin
        held_d = dt;
      end
      unw_d  = unw_step;
      last_d = in_i.angle_wrapped;
      if (fill_q < CW'(WINDOW_DEPTH)) begin
        aw_d[fill_q[IW-1:0]] = unw_step;
        tw_d[fill_q[IW-1:0]] = in_i.time_us;
        fill_d = fill_q + CW'(1);
      end else begin
        for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
          aw_d[k] = aw_q[k+1];
          tw_d[k] = tw_q[k+1];
        end
        aw_d[WINDOW_DEPTH-1] = unw_step;
        tw_d[WINDOW_DEPTH-1] = in_i.time_us;
      end
    end
  end

  assign in_ready_o = room_i;
  assign push_o     = in_valid_i && room_i;

  assign job_angle_o                = aw_d;
  assign job_time_o                 = tw_d;
  assign job_n_o                    = fill_d;
  assign job_res_o.period_us        = held_d;
  assign job_res_o.continuous_angle = unw_d;
  assign job_res_o.ready_res        = (fill_d == CW'(WINDOW_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      fill_q    <= '0;
      last_q    <= '0;
      unw_q     <= '0;
      ltime_q   <= '0;
      held_q    <= '0;
    end else if (push_o) begin
      started_q <= started_d;
      fill_q    <= fill_d;
      last_q    <= last_d;
      unw_q     <= unw_d;
      ltime_q   <= ltime_d;
      held_q    <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      aw_q <= aw_d;
      tw_q <= tw_d;
    end
  end

endmodule
`default_nettype wire

// File: src/uavr_queue.sv
`default_nettype none
module uavr_queue #(
  parameter int WIDTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  room_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  avail_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wptr_q, rptr_q;
  logic [1:0]            cnt_q;

  assign room_o  = (cnt_q != 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// File: src/uavr_back.sv
`default_nettype none
module uavr_back import uavr_pkg::*; #(
  parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  localparam int CW = $clog2(WINDOW_DEPTH + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           avail_i,
  input  wire logic [WINDOW_DEPTH-1:0][31:0]  job_angle_i,
  input  wire logic [WINDOW_DEPTH-1:0][31:0]  job_time_i,
  input  wire logic [CW-1:0]                  job_n_i,
  input  wire res_t                           job_res_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output out_t                                out_o
);

  localparam int LN    = WINDOW_DEPTH - 1;
  localparam int IW    = $clog2(WINDOW_DEPTH);
  localparam int PAIRS = WINDOW_DEPTH * (WINDOW_DEPTH - 1) / 2;
  localparam int ACCW  = 67 + $clog2(PAIRS + 1);
  localparam int NUMW  = ACCW + US_BITS;
  localparam int DIVW  = ACCW + ANGLE_FRAC_BITS + 36;

  bst_e state_q, state_d;

  logic signed [31:0]      pa_q;
  logic [31:0]             pr_q;
  logic [LN-1:0][31:0]     la_q;
  logic [LN-1:0][31:0]     lr_q;
  logic [IW-1:0]           rem_q, cnt_q;
  logic signed [65:0]      pxy_q;
  logic [63:0]             pxx_q;
  logic signed [ACCW-1:0]  sxy_q;
  logic [ACCW-1:0]         sxx_q;
  logic                    neg_q;
  logic [ACCW-1:0]         mag_q;
  logic [NUMW-1:0]         num_q, num_nx;
  logic [4:0]              mcnt_q;
  logic [DIVW-1:0]         rm_q, dv_q;
  logic [4:0]              kcnt_q;
  logic [30:0]             quo_q;
  logic [31:0]             vel_q;
  res_t                    res_q;
  out_t                    out_q;
  logic                    ovalid_q;

  logic                    ge;
  logic                    out_free;
  logic                    out_load;
  logic signed [32:0]      dt, da;
  logic [31:0]             q_fin;

  assign ge       = (rm_q >= dv_q);
  assign out_free = !ovalid_q || out_ready_i;
  assign dt       = $signed({1'b0, lr_q[0]}) - $signed({1'b0, pr_q});
  assign da       = $signed({la_q[0][31], la_q[0]}) - $signed({pa_q[31], pa_q});
  assign num_nx   = US_PER_S[mcnt_q] ? num_q + (NUMW'(mag_q) << mcnt_q) : num_q;
  assign q_fin    = {1'b0, quo_q[29:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (avail_i) begin
          state_d = (job_n_i < CW'(MIN_SAMPLES)) ? B_DONE : B_PAIR;
        end
      end
      B_PAIR: begin
        if (cnt_q == IW'(1) && rem_q == IW'(1)) begin
          state_d = B_DRAIN;
        end
      end
      B_DRAIN: state_d = B_FIN;
      B_FIN:   state_d = (sxx_q == '0) ? B_DONE : B_MUL;
      B_MUL: begin
        if (mcnt_q == 5'(US_BITS - 1)) begin
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if ((kcnt_q == 5'd31 && ge) || kcnt_q == 5'd0) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == B_IDLE) && avail_i;
    out_load = (state_q == B_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          vel_q <= '0;
          res_q <= job_res_i;
          pa_q  <= job_angle_i[0];
          pr_q  <= '0;
          for (int k = 0; k < LN; k++) begin
            la_q[k] <= job_angle_i[k+1];
            lr_q[k] <= job_time_i[k+1] - job_time_i[0];
          end
          rem_q <= IW'(job_n_i - CW'(1));
          cnt_q <= IW'(job_n_i - CW'(1));
          sxy_q <= '0;
          sxx_q <= '0;
          pxy_q <= '0;
          pxx_q <= '0;
        end
      end
      B_PAIR: begin
        sxy_q <= sxy_q + ACCW'(pxy_q);
        sxx_q <= sxx_q + ACCW'(pxx_q);
        pxy_q <= dt * da;
        pxx_q <= 64'(dt * dt);
        if (cnt_q == IW'(1)) begin
          pa_q <= la_q[0];
          pr_q <= lr_q[0];
          for (int k = 0; k < LN - 1; k++) begin
            la_q[k] <= la_q[k+1];
            lr_q[k] <= lr_q[k+1];
          end
          rem_q <= rem_q - IW'(1);
          cnt_q <= rem_q - IW'(1);
        end else begin
          for (int k = 0; k < LN; k++) begin
            if (IW'(k) == rem_q - IW'(1)) begin
              la_q[k] <= la_q[0];
              lr_q[k] <= lr_q[0];
            end else if (k < LN - 1) begin
              la_q[k] <= la_q[(k < LN - 1) ? k + 1 : k];
              lr_q[k] <= lr_q[(k < LN - 1) ? k + 1 : k];
            end
          end
          cnt_q <= cnt_q - IW'(1);
        end
      end
      B_DRAIN: begin
        sxy_q <= sxy_q + ACCW'(pxy_q);
        sxx_q <= sxx_q + ACCW'(pxx_q);
      end
      B_FIN: begin
        neg_q  <= sxy_q[ACCW-1];
        mag_q  <= sxy_q[ACCW-1] ? ACCW'(-sxy_q) : ACCW'(sxy_q);
        num_q  <= '0;
        mcnt_q <= '0;
      end
      B_MUL: begin
        num_q  <= num_nx;
        mcnt_q <= mcnt_q + 5'd1;
        if (mcnt_q == 5'(US_BITS - 1)) begin
          rm_q   <= DIVW'(num_nx) << 16;
          dv_q   <= DIVW'(sxx_q) << (ANGLE_FRAC_BITS + 31);
          kcnt_q <= 5'd31;
        end
      end
      B_DIV: begin
        if (kcnt_q == 5'd31) begin
          if (ge) begin
            vel_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end
        end else begin
          if (ge) begin
            rm_q <= rm_q - dv_q;
          end
          quo_q <= {quo_q[29:0], ge};
          if (kcnt_q == 5'd0) begin
            vel_q <= neg_q ? (32'd0 - q_fin) : q_fin;
          end
        end
        dv_q   <= dv_q >> 1;
        kcnt_q <= kcnt_q - 5'd1;
      end
      B_DONE: begin
        if (out_load) begin
          out_q.velocity         <= vel_q;
          out_q.period_us        <= res_q.period_us;
          out_q.continuous_angle <= res_q.continuous_angle;
          out_q.ready_res        <= res_q.ready_res;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire
